/* hdl/daf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daf_pkg: decimal ASCII formatter shared definitions
// Widths, format codes, ASCII constants and the converter status type.
// ----------------------------------------------------------------------------
package daf_pkg;

  localparam int BIN_W = 16;                 // binary value width
  localparam int DIG_N = 5;                  // decimal digits for BIN_W bits
  localparam int CNT_W = $clog2(BIN_W);      // shift step counter width
  localparam int IDX_W = $clog2(DIG_N);      // digit index width

  typedef logic [3:0]             bcd_digit_t;
  typedef bcd_digit_t [DIG_N-1:0] bcd_word_t;

  typedef struct packed {
    logic      done;                         // one-cycle pulse, bcd is final
    bcd_word_t bcd;
  } conv_status_t;

  // format codes
  localparam logic [1:0] ACT_UNSIGNED = 2'd0;
  localparam logic [1:0] ACT_SIGNED   = 2'd1;
  localparam logic [1:0] ACT_TENTHS   = 2'd2;
  localparam logic [1:0] ACT_NONE     = 2'd3;

  // ASCII
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [3:0] DIGIT_ZONE = 4'h3;  // high nibble of '0'..'9'

endpackage

/* hdl/daf_bcd_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daf_bcd_conv: bit-serial binary to BCD converter
// Shift-add-3 conversion, one binary bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module daf_bcd_conv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [daf_pkg::BIN_W-1:0] bin,
  output daf_pkg::conv_status_t     status
);
  import daf_pkg::*;

  logic [BIN_W-1:0] bin_r, bin_nxt;
  bcd_word_t        bcd_r, bcd_nxt;
  bcd_word_t        adj;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bin_nxt  = bin;
      bcd_nxt  = '0;
      cnt_nxt  = CNT_W'(BIN_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // adjust, then shift the next binary bit in
      bcd_nxt = bcd_word_t'({adj, bin_r[BIN_W-1]});
      bin_nxt = {bin_r[BIN_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign status.done = done_r;
  assign status.bcd  = bcd_r;

endmodule

/* hdl/decimal_ascii_formatter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_ascii_formatter_core: 16-bit value to decimal ASCII text
// The first character follows the bit-serial BCD converter: load, one shift
// step per binary bit, hand-over. A new value is taken only in idle, after
// the last character of the previous one; a converted value gives N = 1..7
// characters, one character per cycle while the output is not stalled.
// Reset (synchronous, active low) returns to idle with no output pending.
// ----------------------------------------------------------------------------
module decimal_ascii_formatter_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [daf_pkg::BIN_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_char_out,
  output logic                      out_last
);
  import daf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [1:0] P_SIGN  = 2'd0;
  localparam logic [1:0] P_DIGIT = 2'd1;
  localparam logic [1:0] P_POINT = 2'd2;
  localparam logic [1:0] P_FRAC  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             neg_r, neg_nxt;
  logic             tenths_r, tenths_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       char_r, char_nxt;
  logic             last_r, last_nxt;

  logic             in_acc;
  logic             out_free;
  logic             neg_in;
  logic [BIN_W-1:0] mag_in;
  logic             conv_start;
  conv_status_t     conv;
  logic [IDX_W-1:0] lo_idx;
  logic [IDX_W-1:0] first_idx;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign neg_in     = (in_action != ACT_UNSIGNED) && in_value[BIN_W-1];
  assign mag_in     = neg_in ? (~in_value + 1'b1) : in_value;
  assign conv_start = in_acc && (in_action != ACT_NONE);

  daf_bcd_conv u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (conv_start),
    .bin    (mag_in),
    .status (conv)
  );

  // lowest digit that must print: the units of the integer part
  assign lo_idx = tenths_r ? IDX_W'(1) : IDX_W'(0);

  always_comb begin
    first_idx = lo_idx;
    for (int i = 1; i < DIG_N; i++) begin
      if (conv.bcd[i] != 4'd0) first_idx = IDX_W'(i);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    tenths_nxt    = tenths_r;
    out_valid_nxt = out_valid_r && out_stall;
    char_nxt      = char_r;
    last_nxt      = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (conv_start) begin
          neg_nxt    = neg_in;
          tenths_nxt = (in_action == ACT_TENTHS);
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        if (conv.done) begin
          phase_nxt = neg_r ? P_SIGN : P_DIGIT;
          idx_nxt   = first_idx;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b0;
          unique case (phase_r)
            P_SIGN: begin
              char_nxt  = CH_MINUS;
              phase_nxt = P_DIGIT;
            end
            P_DIGIT: begin
              char_nxt = {DIGIT_ZONE, conv.bcd[idx_r]};
              if (idx_r == lo_idx) begin
                if (tenths_r) begin
                  phase_nxt = P_POINT;
                end else begin
                  last_nxt  = 1'b1;
                  state_nxt = S_IDLE;
                end
              end else begin
                idx_nxt = idx_r - 1'b1;
              end
            end
            P_POINT: begin
              char_nxt  = CH_POINT;
              phase_nxt = P_FRAC;
            end
            P_FRAC: begin
              char_nxt  = {DIGIT_ZONE, conv.bcd[0]};
              last_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
            default: phase_nxt = P_DIGIT;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_DIGIT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    tenths_r <= tenths_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = char_r;
  assign out_last     = last_r;

endmodule
